/* rtl/ir_ppm_symbol_encoder_top_macros.svh */
// Assertion helpers for the infrared PPM symbol encoder.
`ifndef IR_PPM_SYMBOL_ENCODER_TOP_MACROS_SVH
`define IR_PPM_SYMBOL_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define IRPPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define IRPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/irppm_pkg.sv */
`default_nettype none
package irppm_pkg;

    localparam logic [7:0] BURST4_US  = 8'd40;
    localparam logic [7:0] BURST16_US = 8'd21;
    localparam int unsigned CARRIER_NUM = 126;
    localparam int unsigned CARRIER_DEN = 100;
    localparam logic [5:0] CYC4  = 6'(int'(BURST4_US) * CARRIER_NUM / CARRIER_DEN);
    localparam logic [5:0] CYC16 = 6'(int'(BURST16_US) * CARRIER_NUM / CARRIER_DEN);

    // Segment index of the final gap of a byte.
    localparam logic [2:0] SEG_LAST4  = 3'd7;
    localparam logic [2:0] SEG_LAST16 = 3'd3;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] SPAN4 [4] = '{8'd61, 8'd122, 8'd244, 8'd183};
    localparam logic [7:0] SPAN16 [16] = '{
        8'd27,  8'd51,  8'd35,  8'd43,
        8'd147, 8'd123, 8'd139, 8'd131,
        8'd83,  8'd59,  8'd75,  8'd67,
        8'd91,  8'd115, 8'd99,  8'd107
    };

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_in_frame;
    } t_in_item;

    typedef struct packed {
        logic       segment_is_burst;
        logic [7:0] seg_len_us;
        logic [5:0] carrier_cycles;
        logic       last_of_byte;
        logic       frame_done;
    } t_out_item;

    // One classified byte: mode captured at accept, gap length per symbol.
    typedef struct packed {
        logic            sixteen;
        logic            last_in_frame;
        logic [3:0][7:0] gaps;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] gap4(input logic [1:0] sym);
        return SPAN4[sym] - BURST4_US;
    endfunction

    function automatic logic [7:0] gap16(input logic [3:0] sym);
        return SPAN16[sym] - BURST16_US;
    endfunction

endpackage
`default_nettype wire

/* rtl/irppm_front.sv */
`default_nettype none
module irppm_front
    import irppm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_q_full,
    output logic           o_push,
    output t_entry         o_entry
);

    logic   r_mode;
    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   accept;

    assign o_in_ready = !r_valid || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid && !i_q_full;
    assign o_entry    = r_entry;

    // Decode every symbol of the byte to its gap length.
    always_comb begin
        n_entry.sixteen       = r_mode;
        n_entry.last_in_frame = i_in_data.last_in_frame;
        for (int k = 0; k < 4; k++) begin
            n_entry.gaps[k] = gap4(i_in_data.frame_byte[2*k +: 2]);
        end
        if (r_mode) begin
            n_entry.gaps[0] = gap16(i_in_data.frame_byte[3:0]);
            n_entry.gaps[1] = gap16(i_in_data.frame_byte[7:4]);
            n_entry.gaps[2] = 8'd0;
            n_entry.gaps[3] = 8'd0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule
`default_nettype wire

/* rtl/irppm_queue.sv */
`default_nettype none
module irppm_queue
    import irppm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output t_q_status   o_status
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic [Q_CW-1:0]   n_count;

    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

/* rtl/irppm_back.sv */
`default_nettype none
module irppm_back
    import irppm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_status,
    input  wire t_entry    i_entry,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic [2:0] r_seg;
    logic [2:0] n_seg;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       load;
    logic       is_last;
    logic       burst;

    assign load    = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign is_last = (r_seg == (i_entry.sixteen ? SEG_LAST16 : SEG_LAST4));
    assign burst   = !r_seg[0];
    assign o_pop   = load && is_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Even segments are bursts, odd segments the gap of symbol r_seg/2.
    always_comb begin
        n_out.segment_is_burst = burst;
        if (burst) begin
            n_out.seg_len_us     = i_entry.sixteen ? BURST16_US : BURST4_US;
            n_out.carrier_cycles = i_entry.sixteen ? CYC16 : CYC4;
        end else begin
            n_out.seg_len_us     = i_entry.gaps[r_seg[2:1]];
            n_out.carrier_cycles = 6'd0;
        end
        n_out.last_of_byte = is_last;
        n_out.frame_done   = is_last && i_entry.last_in_frame;
    end

    always_comb begin
        n_seg = r_seg;
        if (load) begin
            n_seg = is_last ? 3'd0 : r_seg + 3'd1;
        end
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_seg       <= n_seg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* rtl/ir_ppm_symbol_encoder_top.sv */
`default_nettype none
// Infrared pulse-position symbol encoder. Each input transaction carries one
// frame byte; it is split into four 2-bit symbols (mode 0) or two nibble
// symbols (mode 1), least significant first, and each symbol leaves as two
// output transactions: a carrier burst (40 us / 50 carrier periods, or 21 us /
// 26 periods) followed by a silent gap of the symbol's table span minus the
// burst. The final gap of a byte flags last_of_byte, and frame_done too when
// the byte was marked last_in_frame. A front stage decodes the byte into gap
// lengths, a two-entry queue holds decoded bytes, and a back sequencer emits
// one segment per cycle into an output register, stalling while the queue is
// empty or the output port is not ready. A byte is thus eight segments in
// four-level mode and four in sixteen-level mode; the front accepts a new
// byte every cycle while the queue has room. The first segment of a byte
// passes through the front register, a queue entry and the output register.
// The mode register is written through the cfg port (always ready) and
// applies to bytes accepted after the write; write it only while idle.
`include "ir_ppm_symbol_encoder_top_macros.svh"
module ir_ppm_symbol_encoder_top
    import irppm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic      push;
    logic      pop;
    t_entry    front_entry;
    t_entry    queue_entry;
    t_q_status q_status;

    // Config writes never stall.
    assign o_cfg_ready = 1'b1;

    irppm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_status.full),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    irppm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    irppm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_entry     (queue_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The queue must never be written while full or read while empty.
    `IRPPM_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, push, !q_status.full, "push while queue full")
    `IRPPM_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, pop, !q_status.empty, "pop while queue empty")
    // A byte always closes on a gap, and frame end only on that gap.
    `IRPPM_ASSERT_NOW(a_last_is_gap, i_clk, i_rst_n, o_out_valid && o_out_data.last_of_byte, !o_out_data.segment_is_burst, "byte closed on a burst")
    // Popping a byte loads its closing segment into the output register.
    `IRPPM_ASSERT_NEXT(a_pop_emits_last, i_clk, i_rst_n, pop, o_out_valid && o_out_data.last_of_byte, "pop without closing segment")

endmodule
`default_nettype wire
